[rtl/core/packbits_run_length_encoder_top_defines.svh]
// Assertion macros for the PackBits run-length encoder.
// Taken in by the top level, which supplies clk and arst_n in scope.
`ifndef PACKBITS_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH
`define PACKBITS_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBRLE_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("PackBits encoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define PBRLE_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("PackBits encoder check failed");

`endif

[rtl/core/pbrle_pkg.sv]
// Package for the PackBits run-length encoder: sizes, sequencer states and operations.
// Has no dependencies; imported by packbits_run_length_encoder_top.
`timescale 1ns / 1ps

package pbrle_pkg;

	localparam int MAX_CHUNK = 128;
	localparam int LIT_AW    = $clog2(MAX_CHUNK);
	localparam int CNT_W     = $clog2(MAX_CHUNK + 1);
	localparam int LANES     = 8;
	localparam int LANE_AW   = $clog2(LANES);
	localparam int LANE_CW   = $clog2(LANES + 1);
	localparam int NUM_OPS   = 6;

	localparam logic [7:0] PAIR_HDR = 8'hFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN_HDR,
		ST_RUN_BYTE,
		ST_ADD,
		ST_FLUSH_HDR,
		ST_FLUSH_DATA,
		ST_END
	} st_t;

	typedef enum logic [2:0] {
		OP_RUN1,
		OP_ADD1,
		OP_FLUSH1,
		OP_RUN2,
		OP_ADD2,
		OP_FLUSH2
	} op_t;

	function automatic op_t pick_op(input logic [NUM_OPS-1:0] m);
		op_t r;
		r = OP_RUN1;
		for (int i = NUM_OPS - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = op_t'(i);
			end
		end
		return r;
	endfunction

	function automatic st_t op_state(input op_t op);
		st_t s;
		if (op inside {OP_RUN1, OP_RUN2}) begin
			s = ST_RUN_HDR;
		end else if (op inside {OP_ADD1, OP_ADD2}) begin
			s = ST_ADD;
		end else begin
			s = ST_FLUSH_HDR;
		end
		return s;
	endfunction

endpackage

[rtl/core/packbits_run_length_encoder_top.sv]
// PackBits run-length encoder: sequencer, literal memory and eight-lane output packer.
// Depends on pbrle_pkg and packbits_run_length_encoder_top_defines.svh.
// A new byte is taken only once the sequencer is back in idle: after acceptance it emits each
// code byte, writes each literal to the store and passes each empty literal flush in turn,
// and it waits through any output stall.
// Results leave through a register. Reset clears control state but not the literal memory.
`timescale 1ns / 1ps
`include "packbits_run_length_encoder_top_defines.svh"

module packbits_run_length_encoder_top
	import pbrle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        code_valid,
	input  logic        code_stall,
	output logic [63:0] packed_bytes,
	output logic [3:0]  byte_count,
	output logic        end_of_burst,
	output logic        end_of_stream
);

	st_t                 state_q, state_d;
	logic [NUM_OPS-1:0]  ops_q, ops_d;
	op_t                 cur_op_q, cur_op_d;
	logic [7:0]          held_byte_q, held_byte_d;
	logic                held_valid_q, held_valid_d;
	logic [CNT_W-1:0]    run_len_q, run_len_d;
	logic [CNT_W-1:0]    lit_cnt_q, lit_cnt_d;
	logic [CNT_W-1:0]    fi_q, fi_d;
	logic [7:0]          run_hdr_q, run_hdr_d;
	logic [7:0]          run_byte_q;
	logic [7:0]          x_q;
	logic                fin_q;

	logic [7:0]          lit_mem [MAX_CHUNK];
	logic [7:0]          rdata_q;
	logic [LIT_AW-1:0]   rd_addr;
	logic                mem_we;
	logic [7:0]          mem_wdata;

	logic [7:0]          lane_q [LANES];
	logic [LANE_CW-1:0]  fcnt_q;
	logic [63:0]         word_flat;

	logic                code_valid_q;
	logic [63:0]         packed_bytes_q;
	logic [3:0]          byte_count_q;
	logic                end_of_burst_q;
	logic                end_of_stream_q;

	logic                accept;
	logic                go;
	logic                emit_v;
	logic [7:0]          emit_byte;
	logic                emit_fire;
	logic                end_fire;
	logic                push_full;

	logic [NUM_OPS-1:0]  ops_new;
	logic [NUM_OPS-1:0]  disp_src;
	op_t                 disp_op;
	st_t                 disp_state;
	logic [NUM_OPS-1:0]  disp_rest;
	logic [CNT_W-1:0]    run_new;
	logic                same;
	logic [CNT_W-1:0]    fi_nxt;

	assign byte_stall = (state_q != ST_IDLE);
	assign accept     = byte_valid && !byte_stall;
	assign go         = !code_valid_q || !code_stall;
	assign emit_fire  = emit_v && go;
	assign push_full  = emit_fire && (fcnt_q == LANE_CW'(LANES));
	assign same       = (data_byte == held_byte_q);
	assign run_new    = run_len_q + CNT_W'(1);
	assign fi_nxt     = fi_q + CNT_W'(1);

	// Decide the operations that one input byte causes.
	always_comb begin
		ops_new      = '0;
		run_hdr_d    = run_hdr_q;
		held_byte_d  = held_byte_q;
		held_valid_d = held_valid_q;
		run_len_d    = run_len_q;
		if (held_valid_q && (run_len_q != '0)) begin
			if (same) begin
				if ((run_new >= CNT_W'(MAX_CHUNK)) || final_byte) begin
					ops_new[OP_RUN1] = 1'b1;
					run_hdr_d        = 8'(8'd1 - 8'(run_new));
					held_valid_d     = 1'b0;
					run_len_d        = '0;
				end else begin
					run_len_d = run_new;
				end
			end else begin
				ops_new[OP_RUN1] = 1'b1;
				run_hdr_d        = 8'(8'd1 - 8'(run_len_q));
				held_byte_d      = data_byte;
				run_len_d        = '0;
				if (final_byte) begin
					ops_new[OP_ADD2]   = 1'b1;
					ops_new[OP_FLUSH2] = 1'b1;
				end
			end
		end else if (held_valid_q) begin
			if (same) begin
				ops_new[OP_FLUSH1] = 1'b1;
				run_len_d          = CNT_W'(2);
				if ((MAX_CHUNK <= 2) || final_byte) begin
					ops_new[OP_RUN2] = 1'b1;
					run_hdr_d        = PAIR_HDR;
					held_valid_d     = 1'b0;
					run_len_d        = '0;
				end
			end else begin
				ops_new[OP_ADD1] = 1'b1;
				if ((lit_cnt_q + CNT_W'(1)) >= CNT_W'(MAX_CHUNK)) begin
					ops_new[OP_FLUSH1] = 1'b1;
				end
				held_byte_d = data_byte;
				if (final_byte) begin
					ops_new[OP_ADD2]   = 1'b1;
					ops_new[OP_FLUSH2] = 1'b1;
				end
			end
		end else begin
			held_byte_d  = data_byte;
			held_valid_d = 1'b1;
			run_len_d    = '0;
			if (final_byte) begin
				ops_new[OP_ADD2]   = 1'b1;
				ops_new[OP_FLUSH2] = 1'b1;
			end
		end
		if (final_byte) begin
			held_byte_d  = '0;
			held_valid_d = 1'b0;
			run_len_d    = '0;
		end
	end

	always_comb begin
		disp_src   = (state_q == ST_IDLE) ? ops_new : ops_q;
		disp_op    = pick_op(disp_src);
		disp_rest  = disp_src & ~(NUM_OPS'(1) << disp_op);
		disp_state = (disp_src != '0) ? op_state(disp_op) : ST_END;
	end

	always_comb begin
		state_d   = state_q;
		ops_d     = ops_q;
		cur_op_d  = cur_op_q;
		lit_cnt_d = lit_cnt_q;
		fi_d      = fi_q;
		emit_v    = 1'b0;
		emit_byte = '0;
		mem_we    = 1'b0;
		mem_wdata = (cur_op_q == OP_ADD1) ? run_byte_q : x_q;
		rd_addr   = '0;
		end_fire  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d  = disp_state;
					ops_d    = disp_rest;
					cur_op_d = disp_op;
				end
			end
			ST_RUN_HDR: begin
				emit_v    = 1'b1;
				emit_byte = run_hdr_q;
				if (go) begin
					state_d = ST_RUN_BYTE;
				end
			end
			ST_RUN_BYTE: begin
				emit_v    = 1'b1;
				emit_byte = run_byte_q;
				if (go) begin
					state_d  = disp_state;
					ops_d    = disp_rest;
					cur_op_d = disp_op;
				end
			end
			ST_ADD: begin
				mem_we    = 1'b1;
				lit_cnt_d = lit_cnt_q + CNT_W'(1);
				state_d   = disp_state;
				ops_d     = disp_rest;
				cur_op_d  = disp_op;
			end
			ST_FLUSH_HDR: begin
				if (lit_cnt_q == '0) begin
					state_d  = disp_state;
					ops_d    = disp_rest;
					cur_op_d = disp_op;
				end else begin
					emit_v    = 1'b1;
					emit_byte = 8'(lit_cnt_q - CNT_W'(1));
					if (go) begin
						state_d = ST_FLUSH_DATA;
						fi_d    = '0;
					end
				end
			end
			ST_FLUSH_DATA: begin
				emit_v    = 1'b1;
				emit_byte = rdata_q;
				rd_addr   = go ? fi_nxt[LIT_AW-1:0] : fi_q[LIT_AW-1:0];
				if (go) begin
					fi_d = fi_nxt;
					if (fi_nxt == lit_cnt_q) begin
						lit_cnt_d = '0;
						state_d   = disp_state;
						ops_d     = disp_rest;
						cur_op_d  = disp_op;
					end
				end
			end
			ST_END: begin
				if (fcnt_q == '0) begin
					state_d = ST_IDLE;
				end else if (go) begin
					end_fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ops_q        <= '0;
			cur_op_q     <= OP_RUN1;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			run_len_q    <= '0;
			lit_cnt_q    <= '0;
			fi_q         <= '0;
		end else begin
			state_q   <= state_d;
			ops_q     <= ops_d;
			cur_op_q  <= cur_op_d;
			lit_cnt_q <= lit_cnt_d;
			fi_q      <= fi_d;
			if (accept) begin
				held_byte_q  <= held_byte_d;
				held_valid_q <= held_valid_d;
				run_len_q    <= run_len_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_hdr_q  <= run_hdr_d;
			run_byte_q <= held_byte_q;
			x_q        <= data_byte;
			fin_q      <= final_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lit_mem[lit_cnt_q[LIT_AW-1:0]] <= mem_wdata;
		end
		rdata_q <= lit_mem[rd_addr];
	end

	// Lane packer: a full word leaves only when the next code byte arrives,
	// so that the last word of a burst can carry its end mark.
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			if ((fcnt_q == '0) || (fcnt_q == LANE_CW'(LANES))) begin
				for (int i = 1; i < LANES; i++) begin
					lane_q[i] <= '0;
				end
				lane_q[0] <= emit_byte;
			end else begin
				lane_q[fcnt_q[LANE_AW-1:0]] <= emit_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
		end else if (emit_fire) begin
			if ((fcnt_q == '0) || (fcnt_q == LANE_CW'(LANES))) begin
				fcnt_q <= LANE_CW'(1);
			end else begin
				fcnt_q <= fcnt_q + LANE_CW'(1);
			end
		end else if (end_fire) begin
			fcnt_q <= '0;
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			word_flat[i*8 +: 8] = lane_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (push_full || end_fire) begin
			code_valid_q <= 1'b1;
		end else if (!code_stall) begin
			code_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_full || end_fire) begin
			packed_bytes_q  <= word_flat;
			byte_count_q    <= 4'(fcnt_q);
			end_of_burst_q  <= end_fire;
			end_of_stream_q <= end_fire && fin_q;
		end
	end

	assign code_valid    = code_valid_q;
	assign packed_bytes  = packed_bytes_q;
	assign byte_count    = byte_count_q;
	assign end_of_burst  = end_of_burst_q;
	assign end_of_stream = end_of_stream_q;

	`PBRLE_ASSERT_NEXT(a_busy_after_accept, accept, byte_stall)
	`PBRLE_ASSERT_SAME(a_count_range, code_valid,
		(byte_count != 4'd0) && (byte_count <= 4'(LANES)))
	`PBRLE_ASSERT_SAME(a_stream_end_is_burst_end, code_valid && end_of_stream, end_of_burst)
	`PBRLE_ASSERT_SAME(a_idle_literals_below_chunk, state_q == ST_IDLE,
		lit_cnt_q < CNT_W'(MAX_CHUNK))

endmodule
